// ----- hw/rtl/tfa_pkg.sv -----
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared types and constants for the timed frame aggregator.
// ----------------------------------------------------------------------------
package tfa_pkg;

    // Field widths
    localparam int TS_W     = 63;
    localparam int PTS_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int TALLY_W  = 21;
    localparam int PERIOD_W = 32;

    // Packed stream widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 248;

    // Result word bit positions (m_tdata)
    localparam int M_PTS_LSB     = 0;
    localparam int M_START_LSB   = 21;
    localparam int M_END_LSB     = 84;
    localparam int M_FIRST_LSB   = 147;
    localparam int M_LAST_LSB    = 179;
    localparam int M_PKTS_LSB    = 211;
    localparam int M_LATE_BIT    = 243;
    localparam int M_GAP_BIT     = 244;
    localparam int M_REORDER_BIT = 245;
    localparam int M_OVF_BIT     = 246;

    // Operation codes (s_tuser)
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // Register index codes (paddr[2])
    localparam logic REG_WINDOW_PERIOD = 1'b0;
    localparam logic REG_MAX_POINTS    = 1'b1;

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 32'd100000000;
    localparam logic [TALLY_W-1:0]  MAXPTS_RESET   = 21'd65536;

    // Bound on the backward sequence step counted as a reorder (steps below it count)
    localparam logic [SEQ_W-1:0] REORDER_SPAN = 32'd1000;

    typedef struct packed {
        logic             op;
        logic [TS_W-1:0]  timestamp_ns;
        logic [PTS_W-1:0] packet_points;
        logic [SEQ_W-1:0] sequence_req;
    } tfa_item_t;

    typedef struct packed {
        logic               frame_valid;
        logic               overflow_drop;
        logic               reorder_seen;
        logic               gap_seen;
        logic               late_drop;
        logic [SEQ_W-1:0]   frame_packets;
        logic [SEQ_W-1:0]   frame_last_seq;
        logic [SEQ_W-1:0]   frame_first_seq;
        logic [TS_W-1:0]    frame_end_ns;
        logic [TS_W-1:0]    frame_start_ns;
        logic [TALLY_W-1:0] frame_points;
    } tfa_result_t;

endpackage

// ----- hw/rtl/tfa_frame_logic.sv -----
// ----------------------------------------------------------------------------
// tfa_frame_logic
// Frame state registers and the single-pass decision logic for one word.
// ----------------------------------------------------------------------------
module tfa_frame_logic
    import tfa_pkg::*;
#(
    parameter int POINT_CEILING = 1048576
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  tfa_item_t           item,
    input  logic [PERIOD_W-1:0] window_period_ns,
    input  logic [TALLY_W-1:0]  max_points_per_frame,
    output tfa_result_t         result
);

    localparam logic [31:0] MAX_PTS32 = POINT_CEILING;

    logic               frame_open_reg, frame_open_next;
    logic [TS_W-1:0]    window_start_reg, window_start_next;
    logic [TS_W-1:0]    window_end_reg, window_end_next;
    logic [SEQ_W-1:0]   first_seq_reg, first_seq_next;
    logic [SEQ_W-1:0]   latest_seq_reg, latest_seq_next;
    logic [SEQ_W-1:0]   packet_tally_reg, packet_tally_next;
    logic [TALLY_W-1:0] point_tally_reg, point_tally_next;
    logic [SEQ_W-1:0]   previous_seq_reg, previous_seq_next;
    logic               previous_seq_valid_reg, previous_seq_valid_next;

    logic               late;
    logic               expire;
    logic               restart;
    logic               emit_expire;
    logic               emit_flush;
    logic               overflow;
    logic               gap;
    logic               reorder;
    logic [TS_W:0]      window_limit;
    logic [TS_W-1:0]    cur_start;
    logic [TS_W-1:0]    base_start;
    logic [TS_W-1:0]    base_end;
    logic [SEQ_W-1:0]   base_first;
    logic [SEQ_W-1:0]   base_latest;
    logic [SEQ_W-1:0]   base_pkts;
    logic [TALLY_W-1:0] base_pts;
    logic [TALLY_W:0]   pts_sum;
    logic [TALLY_W-1:0] limit;
    logic [SEQ_W-1:0]   seq_step;
    logic [SEQ_W-1:0]   seq_back;
    tfa_result_t        desc;

    // Effective point limit: register saturated to the build-time ceiling
    always_comb
    begin
        if ({11'd0, max_points_per_frame} > MAX_PTS32)
            limit = MAX_PTS32[TALLY_W-1:0];
        else
            limit = max_points_per_frame;
    end

    // Window checks against the frame as it stands (or as this packet opens it)
    always_comb
    begin
        cur_start    = frame_open_reg ? window_start_reg : item.timestamp_ns;
        late         = frame_open_reg && (item.timestamp_ns < window_start_reg);
        window_limit = {1'b0, cur_start} + {{(TS_W+1-PERIOD_W){1'b0}}, window_period_ns};
        expire       = !late && ({1'b0, item.timestamp_ns} >= window_limit);
        restart      = !frame_open_reg || expire;
        emit_expire  = expire && frame_open_reg && (point_tally_reg != '0);
        emit_flush   = frame_open_reg && (point_tally_reg != '0);
    end

    // Frame that the packet joins
    always_comb
    begin
        base_start  = restart ? item.timestamp_ns : window_start_reg;
        base_end    = restart ? item.timestamp_ns : window_end_reg;
        base_first  = restart ? item.sequence_req : first_seq_reg;
        base_latest = restart ? item.sequence_req : latest_seq_reg;
        base_pkts   = restart ? '0 : packet_tally_reg;
        base_pts    = restart ? '0 : point_tally_reg;
        pts_sum     = {1'b0, base_pts} + {{(TALLY_W+1-PTS_W){1'b0}}, item.packet_points};
        overflow    = pts_sum > {1'b0, limit};
    end

    // Sequence tracking, kept across frames
    always_comb
    begin
        seq_step = previous_seq_reg + 32'd1;
        seq_back = previous_seq_reg - item.sequence_req;
        gap      = previous_seq_valid_reg && (item.sequence_req != seq_step)
                   && (item.sequence_req > previous_seq_reg);
        reorder  = previous_seq_valid_reg && (item.sequence_req < previous_seq_reg)
                   && (seq_back < REORDER_SPAN);
    end

    // Descriptor of the currently open frame
    always_comb
    begin
        desc                 = '0;
        desc.frame_valid     = 1'b1;
        desc.frame_points    = point_tally_reg;
        desc.frame_start_ns  = window_start_reg;
        desc.frame_end_ns    = window_end_reg;
        desc.frame_first_seq = first_seq_reg;
        desc.frame_last_seq  = latest_seq_reg;
        desc.frame_packets   = packet_tally_reg;
    end

    // Result word
    always_comb
    begin
        result = '0;
        if (item.op == OP_FLUSH)
        begin
            if (emit_flush)
                result = desc;
        end
        else if (late)
        begin
            result.late_drop = 1'b1;
        end
        else
        begin
            if (emit_expire)
                result = desc;
            result.gap_seen      = gap;
            result.reorder_seen  = reorder;
            result.overflow_drop = overflow;
        end
    end

    // Next state
    always_comb
    begin
        frame_open_next         = frame_open_reg;
        window_start_next       = window_start_reg;
        window_end_next         = window_end_reg;
        first_seq_next          = first_seq_reg;
        latest_seq_next         = latest_seq_reg;
        packet_tally_next       = packet_tally_reg;
        point_tally_next        = point_tally_reg;
        previous_seq_next       = previous_seq_reg;
        previous_seq_valid_next = previous_seq_valid_reg;
        if (step)
        begin
            if (item.op == OP_FLUSH)
            begin
                if (emit_flush)
                begin
                    frame_open_next  = 1'b0;
                    point_tally_next = '0;
                end
            end
            else if (!late)
            begin
                frame_open_next         = 1'b1;
                window_start_next       = base_start;
                first_seq_next          = base_first;
                previous_seq_next       = item.sequence_req;
                previous_seq_valid_next = 1'b1;
                if (overflow)
                begin
                    window_end_next   = base_end;
                    latest_seq_next   = base_latest;
                    packet_tally_next = base_pkts;
                    point_tally_next  = base_pts;
                end
                else
                begin
                    window_end_next   = item.timestamp_ns;
                    latest_seq_next   = item.sequence_req;
                    packet_tally_next = base_pkts + 32'd1;
                    point_tally_next  = pts_sum[TALLY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg         <= 1'b0;
            window_start_reg       <= '0;
            window_end_reg         <= '0;
            first_seq_reg          <= '0;
            latest_seq_reg         <= '0;
            packet_tally_reg       <= '0;
            point_tally_reg        <= '0;
            previous_seq_reg       <= '0;
            previous_seq_valid_reg <= 1'b0;
        end
        else
        begin
            frame_open_reg         <= frame_open_next;
            window_start_reg       <= window_start_next;
            window_end_reg         <= window_end_next;
            first_seq_reg          <= first_seq_next;
            latest_seq_reg         <= latest_seq_next;
            packet_tally_reg       <= packet_tally_next;
            point_tally_reg        <= point_tally_next;
            previous_seq_reg       <= previous_seq_next;
            previous_seq_valid_reg <= previous_seq_valid_next;
        end
    end

endmodule

// ----- hw/rtl/timed_frame_aggregator_core.sv -----
// ----------------------------------------------------------------------------
// timed_frame_aggregator_core
// Groups timestamped packet headers into time-window frame descriptors.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. Words are taken at one per
// cycle while the output is not stalled: an accepted word sits in the input
// register, is resolved against the frame state when the output register is
// empty or being drained and lands in the output register, from which m_tvalid
// presents it. A stalled output holds the input register, and s_tready drops
// once that is full. The clock rate is set by the 64-bit add of the window
// period to the frame start timestamp and its compare against the packet
// timestamp. Registers sit at byte addresses 0 (window period, ns) and 4
// (point limit) and should only be written while idle.
module timed_frame_aggregator_core
    import tfa_pkg::*;
#(
    parameter int POINT_CEILING = 1048576
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [62:0] timestamp_ns, [78:63] packet_points, [110:79] sequence_req, [111] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] op
    input  logic                 s_tuser,

    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [20:0] frame_points, [83:21] frame_start_ns, [146:84] frame_end_ns,
    // [178:147] frame_first_seq, [210:179] frame_last_seq,
    // [242:211] frame_packets, [243] late_drop, [244] gap_seen,
    // [245] reorder_seen, [246] overflow_drop, [247] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] frame_valid
    output logic                 m_tuser,

    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic                in_valid_reg, in_valid_next;
    tfa_item_t           in_item_reg;
    logic                out_valid_reg, out_valid_next;
    tfa_result_t         out_result_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [TALLY_W-1:0]  max_points_reg;
    logic                advance;
    logic                cfg_write;
    tfa_result_t         step_result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            max_points_reg <= MAXPTS_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_WINDOW_PERIOD: period_reg     <= pwdata;
                REG_MAX_POINTS:    max_points_reg <= pwdata[TALLY_W-1:0];
                default:           period_reg     <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW_PERIOD: prdata = period_reg;
            REG_MAX_POINTS:    prdata = {{(32-TALLY_W){1'b0}}, max_points_reg};
            default:           prdata = '0;
        endcase
    end

    // Pipeline handshake: the input register moves on whenever the output
    // register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op            <= s_tuser;
            in_item_reg.timestamp_ns  <= s_tdata[62:0];
            in_item_reg.packet_points <= s_tdata[78:63];
            in_item_reg.sequence_req  <= s_tdata[110:79];
        end
        if (advance)
            out_result_reg <= step_result;
    end

    tfa_frame_logic #(
        .POINT_CEILING (POINT_CEILING)
    ) u_frame_logic (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (advance),
        .item                 (in_item_reg),
        .window_period_ns     (period_reg),
        .max_points_per_frame (max_points_reg),
        .result               (step_result)
    );

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.frame_valid;
    assign m_tdata  = {1'b0,
                       out_result_reg.overflow_drop,
                       out_result_reg.reorder_seen,
                       out_result_reg.gap_seen,
                       out_result_reg.late_drop,
                       out_result_reg.frame_packets,
                       out_result_reg.frame_last_seq,
                       out_result_reg.frame_first_seq,
                       out_result_reg.frame_end_ns,
                       out_result_reg.frame_start_ns,
                       out_result_reg.frame_points};

endmodule

// ----- hw/rtl/tfa_checker.sv -----
// ----------------------------------------------------------------------------
// tfa_checker
// Port-level checks on the output words of the frame aggregator.
// ----------------------------------------------------------------------------
module tfa_checker
    import tfa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A stalled output word is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // Without a descriptor all descriptor fields read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[M_LATE_BIT-1:0] == '0)
        else $error("descriptor fields set without frame_valid");

    // A descriptor is only emitted for a frame that holds points
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[M_START_LSB-1:M_PTS_LSB] != '0)
        else $error("empty frame emitted");

    // A late packet touches nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[M_LATE_BIT] |->
            !m_tuser && !m_tdata[M_GAP_BIT] && !m_tdata[M_REORDER_BIT]
            && !m_tdata[M_OVF_BIT])
        else $error("late drop combined with other results");

    // Forward gap and backward reorder cannot both hold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[M_GAP_BIT] && m_tdata[M_REORDER_BIT]))
        else $error("gap and reorder flagged together");

endmodule

bind timed_frame_aggregator_core tfa_checker u_tfa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
